// ===== design/utf8_stream_validator_defines.svh =====
// assertion helpers for the checker file
`ifndef UTF8_STREAM_VALIDATOR_DEFINES_SVH
`define UTF8_STREAM_VALIDATOR_DEFINES_SVH

// same-cycle implication
`define U8V_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define U8V_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/u8v_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package u8v_pkg;

  localparam int DATA_W         = 64;
  localparam int CNT_W          = 4;
  localparam int S_TDATA_W      = 72;
  localparam int M_TDATA_W      = 8;
  localparam int BYTES_PER_ITEM_DEF = 8;

  localparam logic [7:0] BYTE_CONT_LO = 8'h80;
  localparam logic [7:0] BYTE_LEAD_LO = 8'hc0;
  localparam logic [7:0] BYTE_C1      = 8'hc1;
  localparam logic [7:0] BYTE_E0      = 8'he0;
  localparam logic [7:0] BYTE_ED      = 8'hed;
  localparam logic [7:0] BYTE_EF      = 8'hef;
  localparam logic [7:0] BYTE_F0      = 8'hf0;
  localparam logic [7:0] BYTE_F4      = 8'hf4;
  localparam logic [7:0] BYTE_F5      = 8'hf5;
  localparam logic [7:0] BYTE_A0      = 8'ha0;
  localparam logic [7:0] BYTE_9F      = 8'h9f;
  localparam logic [7:0] BYTE_90      = 8'h90;

  typedef enum logic [2:0] {
    RANGE_NONE  = 3'd0,
    RANGE_GE_A0 = 3'd1,
    RANGE_LE_9F = 3'd2,
    RANGE_GE_90 = 3'd3,
    RANGE_LE_8F = 3'd4
  } range_t;

  typedef enum logic [2:0] {
    KIND_ASCII,
    KIND_CONT,
    KIND_LEAD2,
    KIND_LEAD3,
    KIND_LEAD4,
    KIND_BAD
  } kind_t;

  typedef struct packed {
    logic   active;
    kind_t  kind;
    range_t lead_range;
    logic   ge_a0;
    logic   le_9f;
    logic   ge_90;
    logic   le_8f;
  } lane_class_t;

  // continuation byte against the limit left by its lead byte
  function automatic logic cont_ok(lane_class_t cls, range_t rng);
    logic ok;
    unique case (rng)
      RANGE_GE_A0: ok = cls.ge_a0;
      RANGE_LE_9F: ok = cls.le_9f;
      RANGE_GE_90: ok = cls.ge_90;
      RANGE_LE_8F: ok = cls.le_8f;
      default:     ok = 1'b1;
    endcase
    return ok;
  endfunction

endpackage
`default_nettype wire

// ===== design/u8v_lane.sv =====
`timescale 1ns / 1ps
`default_nettype none
module u8v_lane
  import u8v_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        load,
  input  wire logic [7:0]  byte_in,
  input  wire logic        byte_en,
  output lane_class_t      cls
);

  lane_class_t cls_next;

  always_comb begin
    cls_next.active     = byte_en;
    cls_next.lead_range = RANGE_NONE;
    cls_next.ge_a0      = (byte_in >= BYTE_A0);
    cls_next.le_9f      = (byte_in <= BYTE_9F);
    cls_next.ge_90      = (byte_in >= BYTE_90);
    cls_next.le_8f      = (byte_in < BYTE_90);
    priority if (byte_in < BYTE_CONT_LO) begin
      cls_next.kind = KIND_ASCII;
    end else if (byte_in < BYTE_LEAD_LO) begin
      cls_next.kind = KIND_CONT;
    end else if (byte_in <= BYTE_C1) begin
      cls_next.kind = KIND_BAD;
    end else if (byte_in < BYTE_E0) begin
      cls_next.kind = KIND_LEAD2;
    end else if (byte_in <= BYTE_EF) begin
      cls_next.kind = KIND_LEAD3;
      if (byte_in == BYTE_E0) begin
        cls_next.lead_range = RANGE_GE_A0;
      end else if (byte_in == BYTE_ED) begin
        cls_next.lead_range = RANGE_LE_9F;
      end
    end else if (byte_in < BYTE_F5) begin
      cls_next.kind = KIND_LEAD4;
      if (byte_in == BYTE_F0) begin
        cls_next.lead_range = RANGE_GE_90;
      end else if (byte_in == BYTE_F4) begin
        cls_next.lead_range = RANGE_LE_8F;
      end
    end else begin
      cls_next.kind = KIND_BAD;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cls <= cls_next;
    end
  end

endmodule
`default_nettype wire

// ===== design/u8v_merge.sv =====
`timescale 1ns / 1ps
`default_nettype none
module u8v_merge
  import u8v_pkg::*;
#(
  parameter int BYTES_PER_ITEM = BYTES_PER_ITEM_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        adv,
  input  wire logic        word_valid,
  input  wire logic        word_last,
  input  lane_class_t      lanes [BYTES_PER_ITEM],
  output logic             res_valid,
  output logic             res_bit
);

  logic [1:0] pend;
  range_t     rng;
  logic       err;

  logic [1:0] pend_next;
  range_t     rng_next;
  logic       err_next;

  // walk the lanes in byte order, carrying the open sequence
  always_comb begin
    pend_next = pend;
    rng_next  = rng;
    err_next  = err;
    for (int i = 0; i < BYTES_PER_ITEM; i++) begin
      if (lanes[i].active) begin
        if (pend_next != 2'd0) begin
          if (lanes[i].kind == KIND_CONT && cont_ok(lanes[i], rng_next)) begin
            pend_next = pend_next - 2'd1;
          end else begin
            err_next  = 1'b1;
            pend_next = 2'd0;
          end
          rng_next = RANGE_NONE;
        end else begin
          rng_next = RANGE_NONE;
          unique case (lanes[i].kind)
            KIND_ASCII: ;
            KIND_LEAD2: pend_next = 2'd1;
            KIND_LEAD3: begin
              pend_next = 2'd2;
              rng_next  = lanes[i].lead_range;
            end
            KIND_LEAD4: begin
              pend_next = 2'd3;
              rng_next  = lanes[i].lead_range;
            end
            default: err_next = 1'b1;
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend      <= 2'd0;
      rng       <= RANGE_NONE;
      err       <= 1'b0;
      res_valid <= 1'b0;
    end else if (adv) begin
      res_valid <= word_valid && word_last;
      if (word_valid) begin
        if (word_last) begin
          pend <= 2'd0;
          rng  <= RANGE_NONE;
          err  <= 1'b0;
        end else begin
          pend <= pend_next;
          rng  <= rng_next;
          err  <= err_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_bit <= !err_next && (pend_next == 2'd0);
    end
  end

endmodule
`default_nettype wire

// ===== design/utf8_stream_validator.sv =====
// utf8_stream_validator: checks that a byte string is well-formed utf-8
// input stream s_*: one transfer carries up to BYTES_PER_ITEM bytes of the
//   string, byte zero lowest; s_tlast marks the final word of the string
// output stream m_*: exactly one transfer per string, after its last word,
//   with bit 0 of m_tdata set when the whole string is valid
// a word is accepted every cycle while s_tready is high; one stage classifies each byte in its own
//   lane, the next stage chains the lanes in byte order and updates the
//   sequence state, and registers the result once the last transfer reaches it
// sequences may span words; the state clears after each last word
// reset clears the sequence state and drops any pending result
// when m_tready is low with a result held, s_tready drops and the whole
//   pipeline holds until the result is taken
`timescale 1ns / 1ps
`default_nettype none
module utf8_stream_validator
  import u8v_pkg::*;
#(
  parameter int BYTES_PER_ITEM = BYTES_PER_ITEM_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [S_TDATA_W-1:0]  s_tdata,   // data_word[63:0], byte_count[67:64], zero
  input  wire logic                  s_tlast,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [M_TDATA_W-1:0]       m_tdata    // valid_res[0], zero
);

  logic              adv;
  logic              word_valid;
  logic              word_last;
  logic              res_bit;
  logic [DATA_W-1:0] data_word;
  logic [CNT_W-1:0]  byte_count;
  lane_class_t       lanes [BYTES_PER_ITEM];

  assign data_word  = s_tdata[DATA_W-1:0];
  assign byte_count = s_tdata[DATA_W +: CNT_W];

  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= 1'b0;
    end else if (adv) begin
      word_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      word_last <= s_tlast;
    end
  end

  for (genvar i = 0; i < BYTES_PER_ITEM; i++) begin : g_lane
    u8v_lane u_lane (
      .clk     (clk),
      .load    (adv),
      .byte_in (data_word[8*i +: 8]),
      .byte_en (byte_count > CNT_W'(i)),
      .cls     (lanes[i])
    );
  end

  u8v_merge #(
    .BYTES_PER_ITEM (BYTES_PER_ITEM)
  ) u_merge (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .word_valid (word_valid),
    .word_last  (word_last),
    .lanes      (lanes),
    .res_valid  (m_tvalid),
    .res_bit    (res_bit)
  );

  assign m_tdata = {{(M_TDATA_W-1){1'b0}}, res_bit};

endmodule
`default_nettype wire

// ===== design/u8v_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "utf8_stream_validator_defines.svh"
module u8v_checker
  import u8v_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 s_tvalid,
  input wire logic                 s_tready,
  input wire logic                 s_tlast,
  input wire logic                 m_tvalid,
  input wire logic                 m_tready,
  input wire logic [M_TDATA_W-1:0] m_tdata
);

  logic last_xfer;

  assign last_xfer = s_tvalid && s_tready && s_tlast;

  `U8V_ASSERT_NEXT(a_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result dropped or changed while stalled")
  `U8V_ASSERT_NEXT(a_reset, clk, 1'b0, rst, !m_tvalid, "result present after reset")
  `U8V_ASSERT_NOW(a_origin, clk, rst, $rose(m_tvalid), $past(last_xfer, 2), "result without a last transfer")
  `U8V_ASSERT_NOW(a_ready, clk, rst, !m_tvalid, s_tready, "input stalled with no result pending")
  `U8V_ASSERT_NOW(a_pad, clk, rst, m_tvalid, m_tdata[M_TDATA_W-1:1] == '0, "nonzero padding in result")

endmodule

bind utf8_stream_validator u8v_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tlast  (s_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
`default_nettype wire

// ===== tb/sv/utf8_stream_validator_tb.sv =====
`timescale 1ns / 1ps
module utf8_stream_validator_tb;
  import u8v_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_WORDS = 1450;
  localparam int DRAIN_CYCLES = 10;
  localparam int MAX_WAIT = 17;

  localparam logic [7:0] ASCII_HI = 8'h7f;
  localparam logic [7:0] CONT_HI  = 8'hbf;
  localparam logic [7:0] LEAD2_LO = 8'hc2;
  localparam logic [7:0] LEAD2_HI = 8'hdf;
  localparam logic [7:0] LIM_8F   = 8'h8f;
  localparam logic [7:0] BYTE_FF  = 8'hff;

  typedef struct {
    logic [DATA_W-1:0] word;
    logic [CNT_W-1:0]  cnt;
    logic              last;
  } str_word_t;

  typedef enum int {
    CP_ASCII,
    CP_TWO,
    CP_THREE,
    CP_FOUR,
    CP_BAD_LEAD,
    CP_STRAY,
    CP_OUT_OF_RANGE,
    CP_TRUNC,
    CP_NOISE
  } cp_kind_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [S_TDATA_W-1:0]  s_tdata = '0;   // data_word[63:0], byte_count[67:64], zero
  logic                  s_tlast = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_tdata;        // valid_res[0], zero

  str_word_t   word_q[$];
  logic [7:0]  str_q[$];
  bit          verdict_q[$];

  // predictor state
  logic [1:0]  seq_owed;
  range_t      seq_limit;
  bit          seq_bad;

  int          n_mismatch = 0;
  int          n_words_total = 0;
  int          n_words_taken = 0;
  int          idle_cycles = 0;
  int          send_gap = 0;
  int          recv_gap = 0;
  bit          send_calm = 1'b0;
  bit          recv_calm = 1'b0;
  bit          s_took = 1'b0;
  bit          m_took = 1'b0;
  bit          want_valid;
  str_word_t   next_word;

  utf8_stream_validator dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string what);
    $display("ERROR at %0t: %s", $time, what);
    n_mismatch++;
  endtask

  function automatic bit limit_ok(logic [7:0] b, range_t lim);
    case (lim)
      RANGE_GE_A0: return b >= BYTE_A0;
      RANGE_LE_9F: return b <= BYTE_9F;
      RANGE_GE_90: return b >= BYTE_90;
      RANGE_LE_8F: return b <= LIM_8F;
      default:     return 1'b1;
    endcase
  endfunction

  function automatic void utf8_absorb_byte(logic [7:0] b);
    if (seq_owed != 2'd0) begin
      if ((b & BYTE_LEAD_LO) != BYTE_CONT_LO || !limit_ok(b, seq_limit)) begin
        seq_bad = 1'b1;
        seq_owed = 2'd0;
      end else begin
        seq_owed = seq_owed - 2'd1;
      end
      seq_limit = RANGE_NONE;
    end else begin
      seq_limit = RANGE_NONE;
      if (b < BYTE_CONT_LO) begin
        seq_owed = 2'd0;
      end else if (b >= LEAD2_LO && b <= LEAD2_HI) begin
        seq_owed = 2'd1;
      end else if (b >= BYTE_E0 && b <= BYTE_EF) begin
        seq_owed = 2'd2;
        if (b == BYTE_E0) seq_limit = RANGE_GE_A0;
        else if (b == BYTE_ED) seq_limit = RANGE_LE_9F;
      end else if (b >= BYTE_F0 && b <= BYTE_F4) begin
        seq_owed = 2'd3;
        if (b == BYTE_F0) seq_limit = RANGE_GE_90;
        else if (b == BYTE_F4) seq_limit = RANGE_LE_8F;
      end else begin
        seq_bad = 1'b1;
      end
    end
  endfunction

  function automatic void utf8_clear();
    seq_owed = 2'd0;
    seq_limit = RANGE_NONE;
    seq_bad = 1'b0;
  endfunction

  // one accepted transfer: walk its bytes and queue the verdict on the last word
  function automatic void utf8_take_word(logic [DATA_W-1:0] w, logic [CNT_W-1:0] c, logic lst);
    int n;
    n = (c > BYTES_PER_ITEM_DEF) ? BYTES_PER_ITEM_DEF : int'(c);
    for (int i = 0; i < n; i++) utf8_absorb_byte(w[8*i +: 8]);
    if (lst) begin
      verdict_q.push_back(!seq_bad && seq_owed == 2'd0);
      utf8_clear();
    end
  endfunction

  task automatic add_word(input logic [DATA_W-1:0] w, input int c, input bit lst);
    str_word_t it;
    it.word = w;
    it.cnt = c[CNT_W-1:0];
    it.last = lst;
    word_q.push_back(it);
  endtask

  // endpoints get extra weight
  function automatic logic [7:0] pick(logic [7:0] lo, logic [7:0] hi);
    int r;
    r = $urandom_range(0, 3);
    if (r == 0) return lo;
    if (r == 1) return hi;
    return 8'($urandom_range(int'(lo), int'(hi)));
  endfunction

  function automatic void push_cont();
    str_q.push_back(pick(BYTE_CONT_LO, CONT_HI));
  endfunction

  function automatic void append_char(cp_kind_t k);
    logic [7:0] lead;
    int need;
    int r;
    case (k)
      CP_ASCII: str_q.push_back(pick(8'h00, ASCII_HI));
      CP_TWO: begin
        str_q.push_back(pick(LEAD2_LO, LEAD2_HI));
        push_cont();
      end
      CP_THREE: begin
        lead = pick(BYTE_E0, BYTE_EF);
        str_q.push_back(lead);
        if (lead == BYTE_E0) str_q.push_back(pick(BYTE_A0, CONT_HI));
        else if (lead == BYTE_ED) str_q.push_back(pick(BYTE_CONT_LO, BYTE_9F));
        else push_cont();
        push_cont();
      end
      CP_FOUR: begin
        lead = pick(BYTE_F0, BYTE_F4);
        str_q.push_back(lead);
        if (lead == BYTE_F0) str_q.push_back(pick(BYTE_90, CONT_HI));
        else if (lead == BYTE_F4) str_q.push_back(pick(BYTE_CONT_LO, LIM_8F));
        else push_cont();
        push_cont();
        push_cont();
      end
      CP_BAD_LEAD: begin
        r = $urandom_range(0, 2);
        if (r == 0) str_q.push_back(BYTE_LEAD_LO);
        else if (r == 1) str_q.push_back(BYTE_C1);
        else str_q.push_back(pick(BYTE_F5, BYTE_FF));
      end
      CP_STRAY: push_cont();
      CP_OUT_OF_RANGE: begin
        // continuation byte that breaks the limit set by its lead
        r = $urandom_range(0, 3);
        if (r == 0) begin
          str_q.push_back(BYTE_E0);
          str_q.push_back(pick(BYTE_CONT_LO, BYTE_9F));
          push_cont();
        end else if (r == 1) begin
          str_q.push_back(BYTE_ED);
          str_q.push_back(pick(BYTE_A0, CONT_HI));
          push_cont();
        end else if (r == 2) begin
          str_q.push_back(BYTE_F0);
          str_q.push_back(pick(BYTE_CONT_LO, LIM_8F));
          push_cont();
          push_cont();
        end else begin
          str_q.push_back(BYTE_F4);
          str_q.push_back(pick(BYTE_90, CONT_HI));
          push_cont();
          push_cont();
        end
      end
      CP_TRUNC: begin
        lead = pick(LEAD2_LO, BYTE_F4);
        str_q.push_back(lead);
        need = (lead < BYTE_E0) ? 1 : (lead < BYTE_F0) ? 2 : 3;
        r = $urandom_range(0, need - 1);
        for (int i = 0; i < r; i++) push_cont();
      end
      default: str_q.push_back(8'($urandom_range(0, 255)));
    endcase
  endfunction

  // mostly well-formed strings, some with broken sequences or noise mixed in
  task automatic add_string();
    int n_chars;
    int n;
    int rem;
    int pos;
    bit broken;
    logic [DATA_W-1:0] w;
    int c;
    str_q.delete();
    n_chars = $urandom_range(0, 10);
    broken = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < n_chars; i++) begin
      if (broken && $urandom_range(0, 3) == 0)
        append_char(cp_kind_t'($urandom_range(int'(CP_BAD_LEAD), int'(CP_NOISE))));
      else
        append_char(cp_kind_t'($urandom_range(int'(CP_ASCII), int'(CP_FOUR))));
    end
    pos = 0;
    do begin
      rem = str_q.size() - pos;
      if (rem == 0 || $urandom_range(0, 15) == 0) n = 0;
      else n = $urandom_range(1, (rem < BYTES_PER_ITEM_DEF) ? rem : BYTES_PER_ITEM_DEF);
      w = {$urandom, $urandom};
      for (int i = 0; i < n; i++) w[8*i +: 8] = str_q[pos+i];
      c = n;
      if (n == BYTES_PER_ITEM_DEF && $urandom_range(0, 1) == 1) c = $urandom_range(9, 15);
      pos += n;
      add_word(w, c, pos == str_q.size());
    end while (pos < str_q.size());
  endtask

  function automatic int draw_wait(bit calm);
    return calm ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  // sender
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_took) begin
      if (send_gap > 0) begin
        send_gap--;
        s_tvalid <= 1'b0;
      end else if (word_q.size() > 0) begin
        next_word = word_q.pop_front();
        s_tdata <= {{(S_TDATA_W-DATA_W-CNT_W){1'b0}}, next_word.cnt, next_word.word};
        s_tlast <= next_word.last;
        s_tvalid <= 1'b1;
        if ($urandom_range(0, 31) == 0) send_calm = !send_calm;
        send_gap = draw_wait(send_calm);
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_took) begin
        if ($urandom_range(0, 31) == 0) recv_calm = !recv_calm;
        recv_gap = draw_wait(recv_calm);
      end
      if (recv_gap > 0) begin
        recv_gap--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // predictor, checker and watchdog
  always @(posedge clk) begin
    s_took <= !rst && s_tvalid && s_tready;
    m_took <= !rst && m_tvalid && m_tready;
    if (!rst && s_tvalid && s_tready) begin
      utf8_take_word(s_tdata[DATA_W-1:0], s_tdata[DATA_W +: CNT_W], s_tlast);
      n_words_taken++;
    end
    if (!rst && m_tvalid && m_tready) begin
      if (verdict_q.size() == 0) begin
        report_mismatch("result transfer with no string pending");
      end else begin
        want_valid = verdict_q.pop_front();
        if (m_tdata[0] !== want_valid)
          report_mismatch($sformatf("valid_res %b, expected %b", m_tdata[0], want_valid));
      end
    end
    if (!rst && !(s_tvalid && s_tready) && !(m_tvalid && m_tready)) idle_cycles++;
    else idle_cycles = 0;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int target;
    utf8_clear();

    // empty string, ignored bits all ones
    add_word(64'hffff_ffff_ffff_ffff, 0, 1);
    add_word(64'h7f00_4142_4344_0061, 8, 1);
    add_word(64'h0000_0000_bfdf_80c2, 4, 1);
    // lead byte limits, both sides of each
    add_word(64'h0000_0000_0080_a0e0, 3, 1);
    add_word(64'h0000_0000_0080_9fe0, 3, 1);
    add_word(64'h0000_0000_00bf_9fed, 3, 1);
    add_word(64'h0000_0000_0080_a0ed, 3, 1);
    add_word(64'h0000_0000_8080_90f0, 4, 1);
    add_word(64'h0000_0000_8080_8ff0, 4, 1);
    add_word(64'h0000_0000_bfbf_8ff4, 4, 1);
    add_word(64'h0000_0000_8080_90f4, 4, 1);
    // bytes that can never appear
    add_word(64'h0000_0000_0000_80c0, 2, 1);
    add_word(64'h0000_0000_0000_bfc1, 2, 1);
    add_word(64'h0000_0000_8080_80f5, 4, 1);
    // stray continuation
    add_word(64'h0000_0000_0000_0080, 1, 1);
    // sequence cut off by the end of the string
    add_word(64'h0000_0000_0000_82e2, 2, 1);
    add_word(64'h0000_0000_0000_82e2, 2, 0);
    add_word(64'h0000_0000_0000_0000, 0, 1);
    // four-byte sequence split across words
    add_word(64'h0000_0000_0000_9ff0, 2, 0);
    add_word(64'h0000_0000_0000_8098, 2, 1);
    // count above eight saturates
    add_word(64'hbfc2_4141_4141_4141, 12, 1);
    // error then recovery, next string starts clean
    add_word(64'h0000_0000_4141_41ff, 4, 0);
    add_word(64'h0000_0000_0000_0041, 1, 1);
    add_word(64'h0000_0000_0000_0041, 1, 1);
    add_word(64'hffff_ffff_ffff_ffff, 8, 1);

    target = word_q.size() + RANDOM_WORDS;
    while (word_q.size() < target) add_string();
    n_words_total = word_q.size();

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (!(n_words_taken == n_words_total && verdict_q.size() == 0)) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (n_mismatch == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
